@@ hdl/lcdseq_pkg.sv @@
// Shared types, constants and sequencing functions for the character LCD nibble sequencer.
// Used by lcdseq_front, lcdseq_queue, lcdseq_back and the top level.
// Depends on nothing else.
package lcdseq_pkg;

  // Request codes carried in the input item's kind field.
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_INIT   = 3'd1,
    REQ_CMD    = 3'd2,
    REQ_DATA   = 3'd3,
    REQ_CURSOR = 3'd4
  } req_e;

  // Classified operation handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_INIT = 2'd1,
    OP_BYTE = 2'd2,
    OP_NOP  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [7:0]  value;
    logic        sel;
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_BUSY     = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PHASE_TICKS   = 2'd0,
    CFG_SETTLE_TICKS  = 2'd1,
    CFG_POWERUP_TICKS = 2'd2
  } cfg_idx_e;

  // Sequencer phases: H is the high nibble, L the low nibble, R a raw init nibble.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_POWERUP = 4'd1,
    PH_H_LO1   = 4'd2,
    PH_H_HI    = 4'd3,
    PH_H_LO2   = 4'd4,
    PH_L_LO1   = 4'd5,
    PH_L_HI    = 4'd6,
    PH_L_LO2   = 4'd7,
    PH_R_LO1   = 4'd8,
    PH_R_HI    = 4'd9,
    PH_R_LO2   = 4'd10,
    PH_SETTLE  = 4'd11
  } phase_e;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [9:0] settle_ticks;
    logic [9:0] powerup_ticks;
  } cfg_t;

  // Sequencer context that moves from phase to phase.
  typedef struct packed {
    phase_e     phase;
    logic [7:0] pending;
    logic       sel;
    logic [3:0] nibble;
    logic [3:0] step;
  } seq_t;

  localparam logic [7:0]  CursorBase   = 8'h80;
  localparam logic [4:0]  CursorCols   = 5'd16;
  localparam logic [7:0]  PhaseTicksRst   = 8'd1;
  localparam logic [9:0]  SettleTicksRst  = 10'd10;
  localparam logic [9:0]  PowerupTicksRst = 10'd100;
  localparam logic [3:0]  InitNibble   = 4'd3;
  localparam logic [3:0]  ModeNibble   = 4'd2;
  localparam logic [3:0]  StepLastRaw  = 4'd4;
  localparam logic [3:0]  StepFirstCmd = 4'd6;

  // DDRAM address offset of each display row.
  function automatic logic [7:0] row_offset(logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h60;
      default: off = 8'h20;
    endcase
    return off;
  endfunction

  // Commands sent at the end of the init sequence.
  function automatic logic [7:0] init_cmd(logic [2:0] idx);
    logic [7:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h28;
      3'd1:    cmd = 8'h08;
      3'd2:    cmd = 8'h01;
      3'd3:    cmd = 8'h06;
      3'd4:    cmd = 8'h0C;
      default: cmd = 8'h28;
    endcase
    return cmd;
  endfunction

  // Length of a phase in ticks; a pulse phase never lasts less than one tick.
  function automatic logic [9:0] phase_len(phase_e ph, cfg_t cfg);
    logic [9:0] len;
    case (ph)
      PH_IDLE:    len = '0;
      PH_POWERUP: len = cfg.powerup_ticks;
      PH_SETTLE:  len = cfg.settle_ticks;
      default:    len = (cfg.phase_ticks == '0) ? 10'd1 : {2'b00, cfg.phase_ticks};
    endcase
    return len;
  endfunction

  // Successor of the current phase, with its effect on the pins and init step.
  function automatic seq_t next_phase(seq_t s);
    seq_t       n;
    logic [3:0] st;
    logic [3:0] idx;
    n   = s;
    st  = s.step + 4'd1;
    idx = st - StepFirstCmd;
    case (s.phase)
      PH_POWERUP: begin
        n.step   = 4'd1;
        n.sel    = 1'b0;
        n.nibble = InitNibble;
        n.phase  = PH_R_LO1;
      end
      PH_R_LO1: n.phase = PH_R_HI;
      PH_R_HI:  n.phase = PH_R_LO2;
      PH_R_LO2: begin
        if (s.step == StepLastRaw) begin
          n.step   = st;
          n.nibble = ModeNibble;
          n.phase  = PH_R_LO1;
        end else begin
          n.phase = PH_SETTLE;
        end
      end
      PH_H_LO1: n.phase = PH_H_HI;
      PH_H_HI:  n.phase = PH_H_LO2;
      PH_H_LO2: begin
        n.nibble = s.pending[3:0];
        n.phase  = PH_L_LO1;
      end
      PH_L_LO1: n.phase = PH_L_HI;
      PH_L_HI:  n.phase = PH_L_LO2;
      PH_L_LO2: n.phase = s.sel ? PH_IDLE : PH_SETTLE;
      PH_SETTLE: begin
        if (s.step inside {[4'd1:4'd3]}) begin
          n.step   = st;
          n.nibble = InitNibble;
          n.phase  = PH_R_LO1;
        end else if (s.step inside {[4'd5:4'd9]}) begin
          n.step    = st;
          n.pending = init_cmd(idx[2:0]);
          n.sel     = 1'b0;
          n.nibble  = n.pending[7:4];
          n.phase   = PH_H_LO1;
        end else begin
          n.step  = '0;
          n.phase = PH_IDLE;
        end
      end
      default: n.phase = PH_IDLE;
    endcase
    return n;
  endfunction

  // Entering a phase skips it at once if it has no length; only the power-up and
  // settle phases can be empty, and neither is followed by another empty phase.
  function automatic seq_t enter_phase(seq_t s, cfg_t cfg);
    seq_t n;
    n = s;
    if (s.phase != PH_IDLE && phase_len(s.phase, cfg) == '0) begin
      n = next_phase(s);
    end
    return n;
  endfunction

endpackage

@@ hdl/lcdseq_front.sv @@
// Front part of the LCD sequencer: accepts request items and classifies them.
// Uses lcdseq_pkg; feeds lcdseq_queue.
module lcdseq_front (
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [15:0]       s_data_i,   // [7:0] byte_value, [12:8] column, [14:13] row
  input  logic [2:0]        s_user_i,   // [2:0] req_type
  input  logic              q_ready_i,
  output logic              push_o,
  output lcdseq_pkg::op_t   op_o
);

  logic [7:0] byte_value;
  logic [4:0] column;
  logic [1:0] row;

  assign byte_value = s_data_i[7:0];
  assign column     = s_data_i[12:8];
  assign row        = s_data_i[14:13];

  // Items flow straight into the queue whenever it has room.
  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i & q_ready_i;

  // Classify the request; undefined request codes count as ticks.
  always_comb begin
    op_o.kind  = lcdseq_pkg::OP_TICK;
    op_o.value = byte_value;
    op_o.sel   = 1'b0;
    case (s_user_i)
      lcdseq_pkg::REQ_TICK: op_o.kind = lcdseq_pkg::OP_TICK;
      lcdseq_pkg::REQ_INIT: op_o.kind = lcdseq_pkg::OP_INIT;
      lcdseq_pkg::REQ_CMD:  op_o.kind = lcdseq_pkg::OP_BYTE;
      lcdseq_pkg::REQ_DATA: begin
        op_o.kind = lcdseq_pkg::OP_BYTE;
        op_o.sel  = 1'b1;
      end
      lcdseq_pkg::REQ_CURSOR: begin
        // Columns beyond the display send nothing.
        if (column < lcdseq_pkg::CursorCols) begin
          op_o.kind  = lcdseq_pkg::OP_BYTE;
          op_o.value = lcdseq_pkg::CursorBase | {4'b0000, column[3:0]}
                       | lcdseq_pkg::row_offset(row);
        end else begin
          op_o.kind = lcdseq_pkg::OP_NOP;
        end
      end
      default: op_o.kind = lcdseq_pkg::OP_TICK;
    endcase
  end

endmodule

@@ hdl/lcdseq_queue.sv @@
// Short queue of classified operations between the front and back parts.
// Uses lcdseq_pkg for the operation type.
module lcdseq_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcdseq_pkg::op_t   op_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lcdseq_pkg::op_t   op_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  lcdseq_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ hdl/lcdseq_back.sv @@
// Back part of the LCD sequencer: phase sequencer, tick counter, configuration
// registers and the result output register. Uses lcdseq_pkg.
module lcdseq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  input  logic              op_valid_i,
  input  lcdseq_pkg::op_t   op_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [15:0]       m_data_o
);

  lcdseq_pkg::cfg_t     cfg_q;
  lcdseq_pkg::seq_t     seq_q, seq_d;
  logic [9:0]           wait_q, wait_d;
  logic                 active_q, active_d;
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          out_data_q, out_data_d;
  logic [9:0]           wait_dec;
  logic                 busy;
  logic                 enable_lvl;
  lcdseq_pkg::status_e  status;

  // A new operation is taken whenever the output register is free or being emptied.
  assign pop_o     = op_valid_i & (~out_valid_q | m_ready_i);
  assign busy      = (seq_q.phase != lcdseq_pkg::PH_IDLE);
  assign wait_dec  = (wait_q != '0) ? wait_q - 10'd1 : wait_q;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks   <= lcdseq_pkg::PhaseTicksRst;
      cfg_q.settle_ticks  <= lcdseq_pkg::SettleTicksRst;
      cfg_q.powerup_ticks <= lcdseq_pkg::PowerupTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcdseq_pkg::CFG_PHASE_TICKS:   cfg_q.phase_ticks   <= cfg_data_i[7:0];
        lcdseq_pkg::CFG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data_i;
        lcdseq_pkg::CFG_POWERUP_TICKS: cfg_q.powerup_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer step for one operation.
  always_comb begin
    seq_d    = seq_q;
    wait_d   = wait_q;
    active_d = active_q;
    status   = lcdseq_pkg::ST_OK;
    if (pop_o) begin
      case (op_i.kind)
        lcdseq_pkg::OP_TICK: begin
          // Time only moves on ticks; an expired phase hands over to the next.
          if (busy) begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              seq_d  = lcdseq_pkg::enter_phase(lcdseq_pkg::next_phase(seq_q), cfg_q);
              wait_d = lcdseq_pkg::phase_len(seq_d.phase, cfg_q);
            end
          end
        end
        lcdseq_pkg::OP_INIT: begin
          if (busy) begin
            status = lcdseq_pkg::ST_BUSY;
          end else begin
            active_d     = 1'b1;
            seq_d.sel    = 1'b0;
            seq_d.nibble = '0;
            seq_d.step   = '0;
            seq_d.phase  = lcdseq_pkg::PH_POWERUP;
            seq_d        = lcdseq_pkg::enter_phase(seq_d, cfg_q);
            wait_d       = lcdseq_pkg::phase_len(seq_d.phase, cfg_q);
          end
        end
        lcdseq_pkg::OP_BYTE: begin
          if (busy) begin
            status = lcdseq_pkg::ST_BUSY;
          end else if (!active_q) begin
            status = lcdseq_pkg::ST_INACTIVE;
          end else begin
            seq_d.step    = '0;
            seq_d.pending = op_i.value;
            seq_d.sel     = op_i.sel;
            seq_d.nibble  = op_i.value[7:4];
            seq_d.phase   = lcdseq_pkg::PH_H_LO1;
            wait_d        = lcdseq_pkg::phase_len(lcdseq_pkg::PH_H_LO1, cfg_q);
          end
        end
        default: begin
          // A cursor request off the display sends nothing.
          if (busy) begin
            status = lcdseq_pkg::ST_BUSY;
          end else if (!active_q) begin
            status = lcdseq_pkg::ST_INACTIVE;
          end
        end
      endcase
    end
  end

  // Enable is high only in the middle phase of each pulse.
  always_comb begin
    case (seq_d.phase)
      lcdseq_pkg::PH_H_HI, lcdseq_pkg::PH_L_HI, lcdseq_pkg::PH_R_HI: enable_lvl = 1'b1;
      default: enable_lvl = 1'b0;
    endcase
  end

  // Output register: loaded on each taken operation, cleared when emptied.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'b000000, active_d, status,
                     (seq_d.phase != lcdseq_pkg::PH_IDLE),
                     seq_d.nibble, seq_d.sel, enable_lvl};
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.phase   <= lcdseq_pkg::PH_IDLE;
      seq_q.pending <= '0;
      seq_q.sel     <= 1'b0;
      seq_q.nibble  <= '0;
      seq_q.step    <= '0;
      wait_q        <= '0;
      active_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      wait_q      <= wait_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // A running phase always has ticks left to count.
  a_wait_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q.phase != lcdseq_pkg::PH_IDLE) |-> (wait_q != '0))
    else $error("running phase with an empty tick count");

  // The init step is cleared whenever the sequencer is idle.
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q.phase == lcdseq_pkg::PH_IDLE) |-> (seq_q.step == '0))
    else $error("init step left over while idle");

  // A request refused while busy leaves the sequence untouched.
  a_busy_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && op_i.kind != lcdseq_pkg::OP_TICK && busy)
    |=> ($stable(seq_q) && $stable(wait_q)))
    else $error("rejected request disturbed the sequence");

  // Once initialised the display stays active.
  a_active_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |=> active_q)
    else $error("active flag dropped");

endmodule

@@ hdl/char_lcd_nibble_write_sequencer_core.sv @@
// Character LCD nibble write sequencer, top level: front, queue and back part.
// Depends on lcdseq_pkg, lcdseq_front, lcdseq_queue and lcdseq_back.
//
// The block turns tick, init, command, data and cursor requests into the enable,
// register-select and data-nibble levels of a character LCD on a 4-bit bus, and
// returns one result item for every request item. It takes one item per clock
// cycle while the result stream is not held back: the back part's sequencer
// handles any item combinationally, and each result is registered first in the
// queue and then in the output register. Display timing is counted in tick items,
// not clock cycles: each enable phase lasts phase_ticks ticks (at least one),
// settle waits settle_ticks and the power-up wait powerup_ticks. Requests other
// than ticks made while a sequence runs are refused with the busy status.
module char_lcd_nibble_write_sequencer_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] byte_value, [12:8] column, [14:13] row
  input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] lcd_en, [1] select_pin, [5:2] data_nibble,
                                      // [6] busy_res, [8:7] status, [9] active
);

  logic             push;
  logic             q_ready;
  logic             q_valid;
  logic             pop;
  lcdseq_pkg::op_t  front_op;
  lcdseq_pkg::op_t  queue_op;

  // Accept and classify requests.
  lcdseq_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .q_ready_i (q_ready),
    .push_o    (push),
    .op_o      (front_op)
  );

  // Decouple the two sides.
  lcdseq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (queue_op)
  );

  // Run the pin sequence and deliver results.
  lcdseq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (q_valid),
    .op_i        (queue_op),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
